@@ sv/ecif_pkg.sv @@
// Package for the embedded-controller host interface unit.
// Holds action, phase and buffer-source codes, reset command codes and depth defaults.
// No dependencies.
`timescale 1ns / 1ps

package ecif_pkg;

    // Storage defaults
    localparam int SPACE_DEPTH_DEF = 256;
    localparam int EVENT_DEPTH_DEF = 8;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W = 2;

    // Action codes carried in the input tuser
    localparam logic [ACTION_W-1:0] ACT_STATUS_RD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA_RD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CMD_WR    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DATA_WR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LOCAL_WR  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RAISE     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CMD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CMD = 2'd2;

    // Reset values of the command codes
    localparam logic [BYTE_W-1:0] READ_CMD_RST  = 8'h80;
    localparam logic [BYTE_W-1:0] WRITE_CMD_RST = 8'h81;
    localparam logic [BYTE_W-1:0] QUERY_CMD_RST = 8'h84;

    // Transaction phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RADDR = 2'd1;
    localparam logic [1:0] PH_WADDR = 2'd2;
    localparam logic [1:0] PH_WDATA = 2'd3;

    // Where the output buffer byte currently lives
    localparam logic [1:0] OB_REG   = 2'd0;
    localparam logic [1:0] OB_SPACE = 2'd1;
    localparam logic [1:0] OB_EVQ   = 2'd2;

endpackage

@@ sv/embedded_controller_host_interface_unit.sv @@
// Top level of the embedded-controller host interface unit (device side).
// Uses ecif_pkg for codes and defaults; contains the address space and event queue.
// Channel   | dir | handshake              | payload
// s (input) | in  | s_tvalid / s_tready    | s_tuser: action; s_tdata: host byte, local
//           |     |                        |   address, local value, event code
// m (result)| out | m_tvalid / m_tready    | m_tdata: read byte, protocol error, dropped
// cfg       | in  | i_cfg_we               | i_cfg_index, i_cfg_wdata
// An item passes from acceptance through the input register, then one pass of the
// transaction logic into the result register. One word per cycle is sustained while m_tready is high.
// Space and event-queue reads are registered; the output buffer keeps a source tag so
// the read data is picked up by a later data read. Reset is synchronous, active low,
// and clears the space through one valid flip-flop per entry (no clearing pass).
// A stalled result register holds the input register, which back-pressures s_tready.
`timescale 1ns / 1ps

module embedded_controller_host_interface_unit #(
    parameter int SPACE_DEPTH = ecif_pkg::SPACE_DEPTH_DEF,
    parameter int EVENT_DEPTH = ecif_pkg::EVENT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [7:0] host_byte, [15:8] local_address,
                                  // [23:16] local_value, [31:24] event_code
    input  logic [2:0]  s_tuser,  // [2:0] action
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [7:0] read_byte, [8] protocol_error,
                                  // [9] event_dropped, [15:10] zero
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam logic [8:0]    SPACE_LIM = 9'(SPACE_DEPTH);
    localparam logic [EW-1:0] HEAD_LAST = EW'(EVENT_DEPTH - 1);
    localparam logic [CW:0]   EVQ_DEPTH = (CW + 1)'(EVENT_DEPTH);
    localparam logic [CW-1:0] EVQ_FULL  = CW'(EVENT_DEPTH);

    // Configuration registers
    logic [7:0] r_read_cmd, r_write_cmd, r_query_cmd;

    // Input register
    logic       r_in_valid;
    logic [2:0] r_in_action;
    logic [7:0] r_in_hb, r_in_la, r_in_lv, r_in_ev;

    // Result register
    logic        r_m_valid;
    logic [15:0] r_m_data;

    // Transaction state
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_addr, n_addr;
    logic [7:0]    r_obuf, n_obuf;
    logic [1:0]    r_obsrc, n_obsrc;
    logic          r_ofull, n_ofull;
    logic          r_cmd, n_cmd;
    logic [EW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    // Storage
    logic [7:0]             r_space [SPACE_DEPTH];
    logic [SPACE_DEPTH-1:0] r_space_vld;
    logic [7:0]             r_space_rd;
    logic                   r_space_rd_vld;
    logic [7:0]             r_evq [EVENT_DEPTH];
    logic [7:0]             r_evq_rd;

    // Step control
    logic          adv, do_step;
    logic [7:0]    rb, obuf_val;
    logic          perr, drop;
    logic          sp_we, sp_re, eq_we, eq_re;
    logic [7:0]    sp_wa, sp_wd;
    logic [CW:0]   tail_sum;
    logic [EW-1:0] eq_wa;

    assign adv      = !r_m_valid || m_tready;
    assign do_step  = r_in_valid && adv;
    assign s_tready = !r_in_valid || adv;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_cmd  <= ecif_pkg::READ_CMD_RST;
            r_write_cmd <= ecif_pkg::WRITE_CMD_RST;
            r_query_cmd <= ecif_pkg::QUERY_CMD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ecif_pkg::CFG_READ_CMD:  r_read_cmd  <= i_cfg_wdata;
                ecif_pkg::CFG_WRITE_CMD: r_write_cmd <= i_cfg_wdata;
                ecif_pkg::CFG_QUERY_CMD: r_query_cmd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_action <= s_tuser;
            r_in_hb     <= s_tdata[7:0];
            r_in_la     <= s_tdata[15:8];
            r_in_lv     <= s_tdata[23:16];
            r_in_ev     <= s_tdata[31:24];
        end
    end

    // Current output buffer byte, by source
    always_comb begin
        unique case (r_obsrc)
            ecif_pkg::OB_SPACE: obuf_val = r_space_rd_vld ? r_space_rd : 8'd0;
            ecif_pkg::OB_EVQ:   obuf_val = r_evq_rd;
            default:            obuf_val = r_obuf;
        endcase
    end

    // Queue tail slot
    always_comb begin
        tail_sum = {1'b0, (CW)'(r_head)} + {1'b0, r_count};
        if (tail_sum >= EVQ_DEPTH) begin
            tail_sum = tail_sum - EVQ_DEPTH;
        end
        eq_wa = tail_sum[EW-1:0];
    end

    // Transaction logic for one word
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_obuf  = r_obuf;
        n_obsrc = r_obsrc;
        n_ofull = r_ofull;
        n_cmd   = r_cmd;
        n_head  = r_head;
        n_count = r_count;
        rb      = 8'd0;
        perr    = 1'b0;
        drop    = 1'b0;
        sp_we   = 1'b0;
        sp_wa   = r_in_la;
        sp_wd   = r_in_lv;
        sp_re   = 1'b0;
        eq_we   = 1'b0;
        eq_re   = 1'b0;
        unique case (r_in_action)
            ecif_pkg::ACT_STATUS_RD: begin
                rb = {2'b00, (r_count != '0), 1'b0, r_cmd, 2'b00, r_ofull};
            end
            ecif_pkg::ACT_DATA_RD: begin
                rb      = obuf_val;
                n_ofull = 1'b0;
            end
            ecif_pkg::ACT_CMD_WR: begin
                n_cmd = 1'b1;
                priority if (r_in_hb == r_read_cmd) begin
                    n_phase = ecif_pkg::PH_RADDR;
                end else if (r_in_hb == r_write_cmd) begin
                    n_phase = ecif_pkg::PH_WADDR;
                end else if (r_in_hb == r_query_cmd) begin
                    n_phase = ecif_pkg::PH_IDLE;
                    n_ofull = 1'b1;
                    if (r_count != '0) begin
                        eq_re   = 1'b1;
                        n_obsrc = ecif_pkg::OB_EVQ;
                        n_head  = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end else begin
                        n_obuf  = 8'd0;
                        n_obsrc = ecif_pkg::OB_REG;
                    end
                end else begin
                    n_phase = ecif_pkg::PH_IDLE;
                    perr    = 1'b1;
                end
            end
            ecif_pkg::ACT_DATA_WR: begin
                n_cmd = 1'b0;
                unique case (r_phase)
                    ecif_pkg::PH_RADDR: begin
                        n_addr  = r_in_hb;
                        n_ofull = 1'b1;
                        n_phase = ecif_pkg::PH_IDLE;
                        if ({1'b0, r_in_hb} < SPACE_LIM) begin
                            sp_re   = 1'b1;
                            n_obsrc = ecif_pkg::OB_SPACE;
                        end else begin
                            n_obuf  = 8'd0;
                            n_obsrc = ecif_pkg::OB_REG;
                        end
                    end
                    ecif_pkg::PH_WADDR: begin
                        n_addr  = r_in_hb;
                        n_phase = ecif_pkg::PH_WDATA;
                    end
                    ecif_pkg::PH_WDATA: begin
                        sp_wa   = r_addr;
                        sp_wd   = r_in_hb;
                        sp_we   = ({1'b0, r_addr} < SPACE_LIM);
                        n_phase = ecif_pkg::PH_IDLE;
                    end
                    default: begin
                        perr = 1'b1;
                    end
                endcase
            end
            ecif_pkg::ACT_LOCAL_WR: begin
                sp_we = ({1'b0, r_in_la} < SPACE_LIM);
            end
            ecif_pkg::ACT_RAISE: begin
                if (r_count == EVQ_FULL) begin
                    drop = 1'b1;
                end else begin
                    eq_we   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ecif_pkg::PH_IDLE;
            r_addr      <= 8'd0;
            r_obuf      <= 8'd0;
            r_obsrc     <= ecif_pkg::OB_REG;
            r_ofull     <= 1'b0;
            r_cmd       <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_space_vld <= '0;
        end else if (do_step) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_obuf  <= n_obuf;
            r_obsrc <= n_obsrc;
            r_ofull <= n_ofull;
            r_cmd   <= n_cmd;
            r_head  <= n_head;
            r_count <= n_count;
            if (sp_we) begin
                r_space_vld[sp_wa[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Address space memory, registered read
    always_ff @(posedge i_clk) begin
        if (do_step && sp_we) begin
            r_space[sp_wa[AW-1:0]] <= sp_wd;
        end
        if (do_step && sp_re) begin
            r_space_rd     <= r_space[r_in_hb[AW-1:0]];
            r_space_rd_vld <= r_space_vld[r_in_hb[AW-1:0]];
        end
    end

    // Event queue memory, registered read
    always_ff @(posedge i_clk) begin
        if (do_step && eq_we) begin
            r_evq[eq_wa] <= r_in_ev;
        end
        if (do_step && eq_re) begin
            r_evq_rd <= r_evq[r_head];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_m_data <= {6'd0, drop, perr, rb};
        end
    end

endmodule
